### src/y86d_pkg.sv
// Package for the Y86-64 instruction stream decoder.
// Holds payload types, code constants and the small decode tables.
// No dependencies; every other file in src uses it.
package y86d_pkg;

  localparam int unsigned ADDRESS_WIDTH_DEF = 32;
  localparam int unsigned WINDOW_BYTES_DEF  = 10;
  localparam int unsigned BYTE_FIFO_DEPTH   = 2;

  localparam logic [3:0] NO_REG = 4'hF;

  // Instruction codes.
  localparam logic [3:0] IC_HALT   = 4'h0;
  localparam logic [3:0] IC_NOP    = 4'h1;
  localparam logic [3:0] IC_RRMOVQ = 4'h2;
  localparam logic [3:0] IC_IRMOVQ = 4'h3;
  localparam logic [3:0] IC_RMMOVQ = 4'h4;
  localparam logic [3:0] IC_MRMOVQ = 4'h5;
  localparam logic [3:0] IC_OPQ    = 4'h6;
  localparam logic [3:0] IC_JXX    = 4'h7;
  localparam logic [3:0] IC_CALL   = 4'h8;
  localparam logic [3:0] IC_RET    = 4'h9;
  localparam logic [3:0] IC_PUSHQ  = 4'hA;
  localparam logic [3:0] IC_POPQ   = 4'hB;

  localparam logic [3:0] FN_MAX = 4'd6;

  // Result kinds.
  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_QUAD  = 2'd1;
  localparam logic [1:0] KIND_BYTE  = 2'd2;
  localparam logic [1:0] KIND_POS   = 2'd3;

  // Item lengths.
  localparam logic [3:0] LEN_NONE = 4'd0;
  localparam logic [3:0] LEN_1    = 4'd1;
  localparam logic [3:0] LEN_2    = 4'd2;
  localparam logic [3:0] LEN_8    = 4'd8;
  localparam logic [3:0] LEN_9    = 4'd9;
  localparam logic [3:0] LEN_10   = 4'd10;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_START_OFFSET = 1'b0,
    REG_IMAGE_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_PROC
  } state_e;

  typedef enum logic [1:0] {
    ACT_STOP,
    ACT_HALT,
    ACT_ITEM
  } act_e;

  typedef struct packed {
    logic [7:0] data_byte;
  } byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [3:0]  icode;
    logic [2:0]  ifun;
    logic [3:0]  reg_a;
    logic [3:0]  reg_b;
    logic [63:0] value;
    logic [3:0]  length;
    logic        last_of_run;
  } result_t;

  function automatic logic [3:0] ins_len(input logic [3:0] ic);
    logic [3:0] l;
    case (ic)
      IC_HALT, IC_NOP, IC_RET:                l = LEN_1;
      IC_RRMOVQ, IC_OPQ, IC_PUSHQ, IC_POPQ:   l = LEN_2;
      IC_IRMOVQ, IC_RMMOVQ, IC_MRMOVQ:        l = LEN_10;
      IC_JXX, IC_CALL:                        l = LEN_9;
      default:                                l = LEN_NONE;
    endcase
    return l;
  endfunction

  function automatic logic valid_enc(input logic [3:0] ic, input logic [3:0] fn,
                                     input logic [3:0] ra, input logic [3:0] rb);
    logic v;
    case (ic)
      IC_HALT, IC_NOP, IC_CALL, IC_RET: v = (fn == 4'd0);
      IC_RRMOVQ, IC_OPQ:   v = (fn <= FN_MAX) && (ra != NO_REG) && (rb != NO_REG);
      IC_IRMOVQ:           v = (fn == 4'd0) && (ra == NO_REG) && (rb != NO_REG);
      IC_RMMOVQ, IC_MRMOVQ: v = (fn == 4'd0) && (ra != NO_REG) && (rb != NO_REG);
      IC_JXX:              v = (fn <= FN_MAX);
      IC_PUSHQ, IC_POPQ:   v = (fn == 4'd0) && (ra != NO_REG) && (rb == NO_REG);
      default:             v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

### src/y86d_stream_if.sv
// Valid/ready stream interface used for the byte input and the result output.
// The payload type is chosen per instance; types come from y86d_pkg.
interface y86d_stream_if #(
  parameter type payload_t = y86d_pkg::byte_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/y86_instruction_stream_decoder.sv
// Top level of the Y86-64 instruction stream decoder.
// Instantiates y86d_byte_fifo and y86d_framer; uses y86d_pkg and y86d_stream_if.
//
// The decoder takes a Y86-64 memory image one byte per beat on byte_i, in
// address order from start_offset, and delivers framed items on res_o:
// decoded instructions of 1, 2, 9 or 10 bytes, 8-byte data quads, single
// data bytes and position directives. An invalid or truncated encoding is
// re-framed as data from the instruction's first byte: a quad when that
// address is 8-aligned and at least 8 image bytes remain, otherwise a byte.
// Leading halts are dropped and a run of halts yields one halt. The last
// result that a given input byte causes carries last_of_run. Configuration
// registers: index 0 is start_offset (writing it restarts framing), index 1
// is image_length. Write them only while the decoder is idle. Flow: a
// byte waits in a two-entry input queue, enters the byte window, and
// then the framer makes one decision per cycle (emit a result, drop a
// halt, or stop) unless a stalled consumer holds the output; a position
// directive costs one extra decision. The framer takes the next byte
// only after its run stops, and a stalled consumer can hold it behind
// the one-entry output register.
module y86_instruction_stream_decoder #(
  parameter int unsigned ADDRESS_WIDTH = y86d_pkg::ADDRESS_WIDTH_DEF,
  parameter int unsigned WINDOW_BYTES  = y86d_pkg::WINDOW_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  y86d_stream_if.sink   byte_i,
  y86d_stream_if.source res_o
);
  logic       q_valid, q_ready;
  logic [7:0] q_data;

  // Front end: decouples the byte source from the framer.
  y86d_byte_fifo #(
    .DEPTH (y86d_pkg::BYTE_FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .in_ready_o  (byte_i.ready),
    .in_data_i   (byte_i.payload.data_byte),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  // Back end: window, decode decisions and the result register.
  y86d_framer #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .WINDOW_BYTES  (WINDOW_BYTES)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (q_valid),
    .byte_ready_o (q_ready),
    .byte_data_i  (q_data),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res_o.payload)
  );

endmodule

### src/y86d_byte_fifo.sv
// Front queue of the decoder: a short byte FIFO that takes image bytes
// while the framer is busy. Depends on y86d_pkg.
module y86d_byte_fifo #(
  parameter int unsigned DEPTH = y86d_pkg::BYTE_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]    mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign in_ready_o  = (cnt_q != CW'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule

### src/y86d_framer.sv
// Back end of the decoder: byte window, framing decisions and result register.
// One decision step per cycle unless the output stalls; depends on y86d_pkg.
module y86d_framer #(
  parameter int unsigned ADDRESS_WIDTH = y86d_pkg::ADDRESS_WIDTH_DEF,
  parameter int unsigned WINDOW_BYTES  = y86d_pkg::WINDOW_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              byte_valid_i,
  output logic              byte_ready_o,
  input  logic [7:0]        byte_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output y86d_pkg::result_t res_o
);
  localparam int unsigned AW = ADDRESS_WIDTH;
  localparam int unsigned WB = WINDOW_BYTES;
  localparam int unsigned CW = $clog2(WB + 1);
  localparam int unsigned IW = $clog2(WB);
  localparam int unsigned MW = ((AW > 32) ? AW : 32) + 1;

  logic [7:0]           win_q [WB];
  logic [7:0]           win_d [WB];
  logic [CW-1:0]        wc_q, wc_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [31:0]          len_q;
  logic                 at_start_q, at_start_d;
  logic [1:0]           halt_q, halt_d;
  y86d_pkg::state_e     state_q, state_d;
  y86d_pkg::result_t    hold_q, hold_d, out_q, out_d;
  logic                 hold_v_q, hold_v_d, out_v_q, out_v_d;

  logic [3:0]  ic, fn, ra, rb, ilen, step_len;
  logic        enc_ok, have_len, wait_len, quad_ok, need_pos, halt_emit;
  logic [MW-1:0] addr_ext, ilen_ext, rem_full;
  logic [4:0]  rem_sat;
  logic [AW+31:0] cfg_wide;
  logic [AW+31:0] addr_wide;
  y86d_pkg::act_e    act;
  y86d_pkg::result_t cand;
  logic        can_push, start_wr;

  assign cfg_wide  = {{AW{1'b0}}, cfg_data_i};
  assign addr_wide = {32'b0, addr_q};
  assign start_wr  = cfg_we_i && (cfg_index_i == y86d_pkg::REG_START_OFFSET);

  // Bytes left in the image from the current item, saturated for compares.
  always_comb begin
    addr_ext = MW'(addr_q);
    ilen_ext = MW'(len_q);
    rem_full = (ilen_ext > addr_ext) ? ilen_ext - addr_ext : '0;
    rem_sat  = (rem_full > MW'(31)) ? 5'd31 : rem_full[4:0];
  end

  // Classify the byte at the window front and build the candidate result.
  always_comb begin
    ic   = win_q[0][7:4];
    fn   = win_q[0][3:0];
    ilen = y86d_pkg::ins_len(ic);
    if (ilen == y86d_pkg::LEN_2 || ilen == y86d_pkg::LEN_10) begin
      ra = win_q[1][7:4];
      rb = win_q[1][3:0];
    end else begin
      ra = y86d_pkg::NO_REG;
      rb = y86d_pkg::NO_REG;
    end
    enc_ok   = y86d_pkg::valid_enc(ic, fn, ra, rb);
    have_len = (ilen != y86d_pkg::LEN_NONE) && (int'(wc_q) >= int'(ilen));
    wait_len = (ilen != y86d_pkg::LEN_NONE) && (int'(wc_q) < int'(ilen))
               && (int'(rem_sat) > int'(wc_q));
    quad_ok  = (addr_q[2:0] == 3'd0) && (rem_sat >= 5'd8);
    need_pos = (addr_q != '0) && (at_start_q || halt_q > 2'd1);
    halt_emit = !at_start_q && (halt_q == 2'd0);

    cand             = '0;
    cand.address     = addr_wide[31:0];
    step_len         = y86d_pkg::LEN_1;
    act              = y86d_pkg::ACT_STOP;
    if (wc_q == '0 || wait_len) begin
      act = y86d_pkg::ACT_STOP;
    end else if (have_len && enc_ok) begin
      step_len    = ilen;
      cand.kind   = y86d_pkg::KIND_INSTR;
      cand.icode  = ic;
      cand.ifun   = fn[2:0];
      cand.reg_a  = ra;
      cand.reg_b  = rb;
      cand.length = ilen;
      if (ilen == y86d_pkg::LEN_10) begin
        cand.value = {win_q[9], win_q[8], win_q[7], win_q[6],
                      win_q[5], win_q[4], win_q[3], win_q[2]};
      end else if (ilen == y86d_pkg::LEN_9) begin
        cand.value = {win_q[8], win_q[7], win_q[6], win_q[5],
                      win_q[4], win_q[3], win_q[2], win_q[1]};
      end
      act = (ic == y86d_pkg::IC_HALT) ? y86d_pkg::ACT_HALT : y86d_pkg::ACT_ITEM;
    end else if (quad_ok) begin
      if (int'(wc_q) >= 8) begin
        step_len    = y86d_pkg::LEN_8;
        cand.kind   = y86d_pkg::KIND_QUAD;
        cand.length = y86d_pkg::LEN_8;
        cand.value  = {win_q[7], win_q[6], win_q[5], win_q[4],
                       win_q[3], win_q[2], win_q[1], win_q[0]};
        act = y86d_pkg::ACT_ITEM;
      end
    end else begin
      cand.kind   = y86d_pkg::KIND_BYTE;
      cand.length = y86d_pkg::LEN_1;
      cand.value  = {56'b0, win_q[0]};
      act = y86d_pkg::ACT_ITEM;
    end
    // A position directive goes out ahead of the item in a step of its own.
    if (act == y86d_pkg::ACT_ITEM && need_pos) begin
      cand         = '0;
      cand.kind    = y86d_pkg::KIND_POS;
      cand.address = addr_wide[31:0];
    end
  end

  assign can_push = !out_v_q || res_ready_i;
  assign byte_ready_o = (state_q == y86d_pkg::ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      y86d_pkg::ST_IDLE: begin
        if (byte_valid_i) begin
          state_d = y86d_pkg::ST_PROC;
        end
      end
      y86d_pkg::ST_PROC: begin
        if (act == y86d_pkg::ACT_STOP && (!hold_v_q || can_push)) begin
          state_d = y86d_pkg::ST_IDLE;
        end
      end
      default: state_d = y86d_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates for window, flags, held result and output register.
  always_comb begin
    int k;
    logic consume, emit, push;
    y86d_pkg::result_t push_r;
    win_d      = win_q;
    wc_d       = wc_q;
    addr_d     = addr_q;
    at_start_d = at_start_q;
    halt_d     = halt_q;
    hold_d     = hold_q;
    hold_v_d   = hold_v_q;
    k          = int'(step_len);
    consume    = 1'b0;
    emit       = 1'b0;
    push       = 1'b0;
    push_r     = hold_q;
    case (state_q)
      y86d_pkg::ST_IDLE: begin
        if (byte_valid_i && int'(wc_q) < int'(WB)) begin
          win_d[wc_q[IW-1:0]] = byte_data_i;
          wc_d = wc_q + 1'b1;
        end
      end
      y86d_pkg::ST_PROC: begin
        case (act)
          y86d_pkg::ACT_STOP: begin
            if (hold_v_q && can_push) begin
              push             = 1'b1;
              push_r.last_of_run = 1'b1;
              hold_v_d         = 1'b0;
            end
          end
          y86d_pkg::ACT_HALT: begin
            if (!halt_emit || !hold_v_q || can_push) begin
              consume = 1'b1;
              emit    = halt_emit;
              if (!at_start_q && halt_q != 2'd2) begin
                halt_d = halt_q + 1'b1;
              end
            end
          end
          y86d_pkg::ACT_ITEM: begin
            if (!hold_v_q || can_push) begin
              emit       = 1'b1;
              consume    = !need_pos;
              at_start_d = 1'b0;
              halt_d     = 2'd0;
            end
          end
          default: ;
        endcase
        if (emit) begin
          push     = hold_v_q;
          hold_d   = cand;
          hold_v_d = 1'b1;
        end
        if (consume) begin
          for (int i = 0; i < int'(WB); i++) begin
            win_d[i] = (i + k < int'(WB)) ? win_q[i + k] : 8'h00;
          end
          wc_d   = wc_q - CW'(step_len);
          addr_d = addr_q + AW'(step_len);
        end
      end
      default: ;
    endcase
    if (push) begin
      out_d   = push_r;
      out_v_d = 1'b1;
    end else begin
      out_d   = out_q;
      out_v_d = out_v_q && !res_ready_i;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= y86d_pkg::ST_IDLE;
      wc_q       <= '0;
      addr_q     <= '0;
      len_q      <= '0;
      at_start_q <= 1'b1;
      halt_q     <= 2'd0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      if (start_wr) begin
        wc_q       <= '0;
        addr_q     <= cfg_wide[AW-1:0];
        at_start_q <= 1'b1;
        halt_q     <= 2'd0;
      end else begin
        wc_q       <= wc_d;
        addr_q     <= addr_d;
        at_start_q <= at_start_d;
        halt_q     <= halt_d;
      end
      if (cfg_we_i && cfg_index_i == y86d_pkg::REG_IMAGE_LENGTH) begin
        len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

endmodule
